@@ rtl/pscm_pkg.sv @@
// Shared widths, codes and types of the pileup site mutation classifier.
package pscm_pkg;

    // Read counts and running totals
    localparam int READ_COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH      = 40;
    localparam int LANE_W           = 16;   // lane pitch in the packed count words
    localparam int NUM_BASES        = 4;

    // Config register widths
    localparam int MAC_W = 19;  // min ancestor coverage
    localparam int MFI_W = 8;   // max freq inverse
    localparam int DIV_W = 10;  // min freq divisor
    localparam int MAR_W = 7;   // margin in hundredths
    localparam int CFG_W = MAC_W;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int SUM_W     = READ_COUNT_WIDTH + 1;     // per-base fwd+rev
    localparam int COV_W     = READ_COUNT_WIDTH + 3;     // eight counts
    localparam int MF_W      = SUM_W + MFI_W;
    localparam int MD_W      = SUM_W + DIV_W;
    localparam int S_W       = SUM_W + 1;                // signed 2f - t
    localparam int SQ_W      = 2 * S_W;
    localparam int A2_W      = 2 * MAR_W;
    localparam int A3_W      = A2_W + 2;
    localparam int D2_W      = 2 * DIV_W;
    localparam int T1_W      = A3_W + COV_W;
    localparam int T1_LO_W   = T1_W / 2;
    localparam int T1_HI_W   = T1_W - T1_LO_W;
    localparam int PLO_W     = T1_LO_W + D2_W;
    localparam int PHI_W     = T1_HI_W + D2_W;
    localparam int RHS_W     = T1_W + D2_W;
    localparam int DIFF_W    = MD_W;
    localparam int LHS_W     = 2 * DIFF_W;
    localparam int L10K_W    = LHS_W + 14;

    // Base codes
    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_G    = 3'd3;
    localparam logic [2:0] BASE_NONE = 3'd4;

    typedef enum logic [2:0] {
        OC_MUTED      = 3'd0,
        OC_UNMUTED    = 3'd1,
        OC_BAD_BASE   = 3'd2,
        OC_LOW_COV    = 3'd3,
        OC_ANC_VAR    = 3'd4,
        OC_FREQ_HIGH  = 3'd5,
        OC_STRAND     = 3'd6,
        OC_MISMATCH   = 3'd7
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANC_COV  = 2'd0,
        CFG_MAX_FREQ_INV = 2'd1,
        CFG_MIN_FREQ_DIV = 2'd2,
        CFG_MARGIN       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MAC_W-1:0] min_anc_cov;
        logic [MFI_W-1:0] max_freq_inv;
        logic [DIV_W-1:0] min_freq_div;
        logic [MAR_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  aref;
        logic [63:0] afwd;
        logic [63:0] arev;
        logic [2:0]  eref;
        logic [63:0] efwd;
        logic [63:0] erev;
    } t_site;

    typedef struct packed {
        t_outcome   outcome;
        logic [2:0] allele;
    } t_cls;

endpackage

@@ rtl/pscm_site_if.sv @@
// Site input channel: one genome site per beat.
interface pscm_site_if;
    logic        valid;
    logic        ready;
    logic [2:0]  ancestor_base;
    logic [63:0] ancestor_forward_counts;
    logic [63:0] ancestor_reverse_counts;
    logic [2:0]  endpoint_base;
    logic [63:0] endpoint_forward_counts;
    logic [63:0] endpoint_reverse_counts;

    modport source (
        output valid, ancestor_base, ancestor_forward_counts,
               ancestor_reverse_counts, endpoint_base,
               endpoint_forward_counts, endpoint_reverse_counts,
        input  ready
    );

    modport sink (
        input  valid, ancestor_base, ancestor_forward_counts,
               ancestor_reverse_counts, endpoint_base,
               endpoint_forward_counts, endpoint_reverse_counts,
        output ready
    );
endinterface

@@ rtl/pscm_result_if.sv @@
// Result channel: site outcome, dominant allele and running totals per beat.
interface pscm_result_if
    import pscm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [2:0]             outcome;
    logic [2:0]             muted_allele;
    logic [TOTAL_WIDTH-1:0] muted_total;
    logic [TOTAL_WIDTH-1:0] unmuted_total;
    logic [TOTAL_WIDTH-1:0] discarded_total;

    modport source (
        output valid, outcome, muted_allele, muted_total, unmuted_total,
               discarded_total,
        input  ready
    );

    modport sink (
        input  valid, outcome, muted_allele, muted_total, unmuted_total,
               discarded_total,
        output ready
    );
endinterface

@@ rtl/pscm_pipe.sv @@
// Seven-stage classification pipeline: sums, dominant allele, checks, cutoff test.
module pscm_pipe
    import pscm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_site i_site,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_cls  o_cls
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_vld;

    // Stage 1: per-base sums
    logic [SUM_W-1:0]            n_s1_asum [NUM_BASES];
    logic [SUM_W-1:0]            n_s1_esum [NUM_BASES];
    logic [READ_COUNT_WIDTH-1:0] n_s1_ef   [NUM_BASES];
    logic [SUM_W-1:0]            r_s1_asum [NUM_BASES];
    logic [SUM_W-1:0]            r_s1_esum [NUM_BASES];
    logic [READ_COUNT_WIDTH-1:0] r_s1_ef   [NUM_BASES];
    logic [2:0]                  r_s1_aref;
    logic [2:0]                  r_s1_eref;

    // Stage 2: coverage, dominant allele, ancestor check
    logic [COV_W-1:0] n_s2_acov, n_s2_ecov;
    logic [2:0]       n_s2_allele;
    logic [SUM_W-1:0] n_s2_m;
    logic [READ_COUNT_WIDTH-1:0] n_s2_f;
    logic             n_s2_anc;
    logic [COV_W-1:0] r_s2_acov, r_s2_ecov;
    logic [2:0]       r_s2_allele;
    logic [SUM_W-1:0] r_s2_m;
    logic [READ_COUNT_WIDTH-1:0] r_s2_f;
    logic             r_s2_bad, r_s2_mis, r_s2_anc;

    // Stage 3: early discard code and products
    logic             n_s3_early;
    t_outcome         n_s3_code;
    logic signed [S_W-1:0] n_s3_s;
    logic [S_W-1:0]   n_s3_sabs;
    logic             r_s3_early;
    t_outcome         r_s3_code;
    logic [2:0]       r_s3_allele;
    logic [COV_W-1:0] r_s3_ecov;
    logic [SUM_W-1:0] r_s3_m;
    logic [MF_W-1:0]  r_s3_mf;
    logic [MD_W-1:0]  r_s3_md;
    logic [SQ_W-1:0]  r_s3_s2;
    logic [A2_W-1:0]  r_s3_a2;
    logic [D2_W-1:0]  r_s3_d2;
    logic             r_s3_nz;

    // Stage 4: frequency and strand checks, margin term
    logic             n_s4_freq, n_s4_strand;
    t_outcome         n_s4_code;
    logic [A3_W-1:0]  n_s4_a3;
    logic             r_s4_pend;
    t_outcome         r_s4_code;
    logic [2:0]       r_s4_allele;
    logic             r_s4_cand;
    logic [DIFF_W-1:0] r_s4_diff;
    logic [T1_W-1:0]  r_s4_t1;
    logic [D2_W-1:0]  r_s4_d2;

    // Stage 5: squares and partial products
    logic             r_s5_pend;
    t_outcome         r_s5_code;
    logic [2:0]       r_s5_allele;
    logic             r_s5_cand;
    logic [LHS_W-1:0] r_s5_lhs;
    logic [PLO_W-1:0] r_s5_plo;
    logic [PHI_W-1:0] r_s5_phi;

    // Stage 6: scaled sides of the cutoff test
    logic             r_s6_pend;
    t_outcome         r_s6_code;
    logic [2:0]       r_s6_allele;
    logic             r_s6_cand;
    logic [L10K_W-1:0] r_s6_l10k;
    logic [RHS_W-1:0] r_s6_rhs;

    // Stage 7: final classification
    logic             n_s7_muted;
    t_cls             n_s7_cls;
    t_cls             r_s7_cls;

    // Valid bits advance with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // Stage 1 logic
    always_comb begin
        for (int i = 0; i < NUM_BASES; i++) begin
            n_s1_asum[i] = SUM_W'(i_site.afwd[LANE_W*i +: READ_COUNT_WIDTH])
                         + SUM_W'(i_site.arev[LANE_W*i +: READ_COUNT_WIDTH]);
            n_s1_esum[i] = SUM_W'(i_site.efwd[LANE_W*i +: READ_COUNT_WIDTH])
                         + SUM_W'(i_site.erev[LANE_W*i +: READ_COUNT_WIDTH]);
            n_s1_ef[i]   = i_site.efwd[LANE_W*i +: READ_COUNT_WIDTH];
        end
    end

    // Stage 2 logic: later base wins ties
    always_comb begin
        n_s2_acov   = '0;
        n_s2_ecov   = '0;
        n_s2_allele = BASE_NONE;
        n_s2_m      = '0;
        n_s2_anc    = 1'b0;
        for (int i = 0; i < NUM_BASES; i++) begin
            n_s2_acov = n_s2_acov + COV_W'(r_s1_asum[i]);
            n_s2_ecov = n_s2_ecov + COV_W'(r_s1_esum[i]);
            if (3'(i) != r_s1_aref && r_s1_asum[i] != '0) begin
                n_s2_anc = 1'b1;
            end
            if (r_s1_eref <= BASE_G && 3'(i) != r_s1_eref
                    && r_s1_esum[i] != '0 && r_s1_esum[i] >= n_s2_m) begin
                n_s2_m      = r_s1_esum[i];
                n_s2_allele = 3'(i);
            end
        end
        n_s2_f = r_s1_ef[n_s2_allele[1:0]];
    end

    // Stage 3 logic: discard priority up to the ancestor check
    always_comb begin
        n_s3_early = 1'b1;
        n_s3_code  = OC_BAD_BASE;
        if (r_s2_bad) begin
            n_s3_code = OC_BAD_BASE;
        end else if (r_s2_mis) begin
            n_s3_code = OC_MISMATCH;
        end else if (MAC_W'(r_s2_acov) < i_cfg.min_anc_cov) begin
            n_s3_code = OC_LOW_COV;
        end else if (r_s2_anc) begin
            n_s3_code = OC_ANC_VAR;
        end else begin
            n_s3_early = 1'b0;
        end
        // Strand skew: 2f - t
        n_s3_s    = $signed(S_W'({r_s2_f, 1'b0})) - $signed(S_W'(r_s2_m));
        n_s3_sabs = n_s3_s[S_W-1] ? S_W'(-n_s3_s) : S_W'(n_s3_s);
    end

    // Stage 4 logic
    always_comb begin
        n_s4_freq   = r_s3_mf > MF_W'(r_s3_ecov);
        n_s4_strand = (r_s3_allele != BASE_NONE) && (r_s3_s2 > SQ_W'({r_s3_m, 2'b00}));
        if (r_s3_early) begin
            n_s4_code = r_s3_code;
        end else if (n_s4_freq) begin
            n_s4_code = OC_FREQ_HIGH;
        end else begin
            n_s4_code = OC_STRAND;
        end
        n_s4_a3 = A3_W'(r_s3_a2) + A3_W'({r_s3_a2, 1'b0});
    end

    // Stage 7 logic: 10000*(mD-cov)^2 >= 3*a^2*cov*D^2
    always_comb begin
        n_s7_muted      = r_s6_cand && (r_s6_l10k >= L10K_W'(r_s6_rhs));
        n_s7_cls.allele = r_s6_allele;
        if (!r_s6_pend) begin
            n_s7_cls.outcome = r_s6_code;
        end else if (n_s7_muted) begin
            n_s7_cls.outcome = OC_MUTED;
        end else begin
            n_s7_cls.outcome = OC_UNMUTED;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_s1_asum <= n_s1_asum;
            r_s1_esum <= n_s1_esum;
            r_s1_ef   <= n_s1_ef;
            r_s1_aref <= i_site.aref;
            r_s1_eref <= i_site.eref;
            // stage 2
            r_s2_acov   <= n_s2_acov;
            r_s2_ecov   <= n_s2_ecov;
            r_s2_allele <= n_s2_allele;
            r_s2_m      <= n_s2_m;
            r_s2_f      <= n_s2_f;
            r_s2_bad    <= (r_s1_aref > BASE_G) || (r_s1_eref > BASE_G);
            r_s2_mis    <= r_s1_aref != r_s1_eref;
            r_s2_anc    <= n_s2_anc;
            // stage 3
            r_s3_early  <= n_s3_early;
            r_s3_code   <= n_s3_code;
            r_s3_allele <= r_s2_allele;
            r_s3_ecov   <= r_s2_ecov;
            r_s3_m      <= r_s2_m;
            r_s3_mf     <= MF_W'(r_s2_m) * MF_W'(i_cfg.max_freq_inv);
            r_s3_md     <= MD_W'(r_s2_m) * MD_W'(i_cfg.min_freq_div);
            r_s3_s2     <= SQ_W'(n_s3_sabs) * SQ_W'(n_s3_sabs);
            r_s3_a2     <= A2_W'(i_cfg.margin) * A2_W'(i_cfg.margin);
            r_s3_d2     <= D2_W'(i_cfg.min_freq_div) * D2_W'(i_cfg.min_freq_div);
            r_s3_nz     <= (r_s2_ecov != '0) && (i_cfg.min_freq_div != '0);
            // stage 4
            r_s4_pend   <= !r_s3_early && !n_s4_freq && !n_s4_strand;
            r_s4_code   <= n_s4_code;
            r_s4_allele <= r_s3_allele;
            r_s4_cand   <= r_s3_nz && (r_s3_md >= MD_W'(r_s3_ecov));
            r_s4_diff   <= r_s3_md - MD_W'(r_s3_ecov);
            r_s4_t1     <= T1_W'(n_s4_a3) * T1_W'(r_s3_ecov);
            r_s4_d2     <= r_s3_d2;
            // stage 5
            r_s5_pend   <= r_s4_pend;
            r_s5_code   <= r_s4_code;
            r_s5_allele <= r_s4_allele;
            r_s5_cand   <= r_s4_cand;
            r_s5_lhs    <= LHS_W'(r_s4_diff) * LHS_W'(r_s4_diff);
            r_s5_plo    <= PLO_W'(r_s4_t1[T1_LO_W-1:0]) * PLO_W'(r_s4_d2);
            r_s5_phi    <= PHI_W'(r_s4_t1[T1_W-1:T1_LO_W]) * PHI_W'(r_s4_d2);
            // stage 6: 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
            r_s6_pend   <= r_s5_pend;
            r_s6_code   <= r_s5_code;
            r_s6_allele <= r_s5_allele;
            r_s6_cand   <= r_s5_cand;
            r_s6_l10k   <= (L10K_W'(r_s5_lhs) << 13) + (L10K_W'(r_s5_lhs) << 10)
                         + (L10K_W'(r_s5_lhs) << 9)  + (L10K_W'(r_s5_lhs) << 8)
                         + (L10K_W'(r_s5_lhs) << 4);
            r_s6_rhs    <= RHS_W'(r_s5_plo) + (RHS_W'(r_s5_phi) << T1_LO_W);
            // stage 7
            r_s7_cls    <= n_s7_cls;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_cls   = r_s7_cls;

endmodule

@@ rtl/pileup_site_mutation_classifier_unit.sv @@
// Top level of the pileup site mutation classifier: config, pipeline, totals, output beat.
//
// Usage:
//   i_site carries one genome site per beat (ancestor and endpoint reference
//   bases plus packed forward/reverse A,T,C,G counts). o_result returns one
//   beat per site, in order: outcome code, dominant non-reference endpoint
//   allele, and the muted / not muted / discarded totals including that site.
//   Config registers are written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no site is in flight.
// Timing:
//   Throughput is one site per clock while the output beat is not held. A site
//   passes through seven pipeline stages (sums, dominant allele, discard checks,
//   three multiply stages of the cutoff test, compare) and then the output
//   register, which drives o_result.valid.
// Reset:
//   Synchronous, active low. Clears the pipeline valids, the output beat valid and
//   the totals; config registers return to 100, 5, 8 and 52.
// Backpressure:
//   While the output beat is held and not taken, the whole pipeline freezes
//   and i_site.ready drops; nothing is lost or repeated.
module pileup_site_mutation_classifier_unit
    import pscm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pscm_site_if.sink            i_site,
    pscm_result_if.source        o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    t_site site;
    logic  en;
    logic  pipe_valid;
    t_cls  pipe_cls;

    logic [TOTAL_WIDTH-1:0] r_muted_cnt, r_unmuted_cnt, r_discard_cnt;
    logic [TOTAL_WIDTH-1:0] n_muted_cnt, n_unmuted_cnt, n_discard_cnt;

    logic                   r_out_valid;
    t_outcome               r_out_outcome;
    logic [2:0]             r_out_allele;
    logic [TOTAL_WIDTH-1:0] r_out_muted, r_out_unmuted, r_out_discard;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_anc_cov  <= MAC_W'(100);
            r_cfg.max_freq_inv <= MFI_W'(5);
            r_cfg.min_freq_div <= DIV_W'(8);
            r_cfg.margin       <= MAR_W'(52);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_ANC_COV:  r_cfg.min_anc_cov  <= i_cfg_data[MAC_W-1:0];
                CFG_MAX_FREQ_INV: r_cfg.max_freq_inv <= i_cfg_data[MFI_W-1:0];
                CFG_MIN_FREQ_DIV: r_cfg.min_freq_div <= i_cfg_data[DIV_W-1:0];
                CFG_MARGIN:       r_cfg.margin       <= i_cfg_data[MAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances whenever the output slot is free or being taken
    assign en           = !r_out_valid || o_result.ready;
    assign i_site.ready = en;

    assign site.aref = i_site.ancestor_base;
    assign site.afwd = i_site.ancestor_forward_counts;
    assign site.arev = i_site.ancestor_reverse_counts;
    assign site.eref = i_site.endpoint_base;
    assign site.efwd = i_site.endpoint_forward_counts;
    assign site.erev = i_site.endpoint_reverse_counts;

    pscm_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_site.valid),
        .i_site  (site),
        .i_cfg   (r_cfg),
        .o_valid (pipe_valid),
        .o_cls   (pipe_cls)
    );

    // Running totals, wrapping
    always_comb begin
        n_muted_cnt   = r_muted_cnt;
        n_unmuted_cnt = r_unmuted_cnt;
        n_discard_cnt = r_discard_cnt;
        case (pipe_cls.outcome)
            OC_MUTED:   n_muted_cnt   = r_muted_cnt + TOTAL_WIDTH'(1);
            OC_UNMUTED: n_unmuted_cnt = r_unmuted_cnt + TOTAL_WIDTH'(1);
            default:    n_discard_cnt = r_discard_cnt + TOTAL_WIDTH'(1);
        endcase
    end

    // Totals and output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_muted_cnt   <= '0;
            r_unmuted_cnt <= '0;
            r_discard_cnt <= '0;
        end else if (en) begin
            r_out_valid <= pipe_valid;
            if (pipe_valid) begin
                r_muted_cnt   <= n_muted_cnt;
                r_unmuted_cnt <= n_unmuted_cnt;
                r_discard_cnt <= n_discard_cnt;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (en && pipe_valid) begin
            r_out_outcome <= pipe_cls.outcome;
            r_out_allele  <= pipe_cls.allele;
            r_out_muted   <= n_muted_cnt;
            r_out_unmuted <= n_unmuted_cnt;
            r_out_discard <= n_discard_cnt;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.outcome         = r_out_outcome;
    assign o_result.muted_allele    = r_out_allele;
    assign o_result.muted_total     = r_out_muted;
    assign o_result.unmuted_total   = r_out_unmuted;
    assign o_result.discarded_total = r_out_discard;

endmodule

@@ test/pileup_site_mutation_classifier_unit_tb.sv @@
// Self-checking testbench of the pileup site mutation classifier: predicted verdicts vs DUT.
`timescale 1ns / 1ps

module pileup_site_mutation_classifier_unit_tb
    import pscm_pkg::*;
;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_SUM      = 131070;   // fwd + rev of one lane

    // Expected result beat of one site
    typedef struct {
        t_outcome               outcome;
        logic [2:0]             allele;
        logic [TOTAL_WIDTH-1:0] muted;
        logic [TOTAL_WIDTH-1:0] unmuted;
        logic [TOTAL_WIDTH-1:0] discarded;
    } t_site_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    pscm_site_if   site_ch ();
    pscm_result_if res_ch ();

    pileup_site_mutation_classifier_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_site      (site_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow config and running totals
    logic [MAC_W-1:0]       min_anc_cov  = 19'd100;
    logic [MFI_W-1:0]       max_freq_inv = 8'd5;
    logic [DIV_W-1:0]       min_freq_div = 10'd8;
    logic [MAR_W-1:0]       margin       = 7'd52;
    logic [TOTAL_WIDTH-1:0] muted_cnt     = '0;
    logic [TOTAL_WIDTH-1:0] unmuted_cnt   = '0;
    logic [TOTAL_WIDTH-1:0] discarded_cnt = '0;

    t_site         pending_sites[$];
    t_site_verdict expected_verdicts[$];
    t_site         offered_site;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int          gap_max     = 0;
    int          gap_left    = 0;
    int          burst_left  = 0;
    int          rdy_mode    = 0;
    logic [7:0]  rdy_pattern = 8'hFF;
    int          holds_asked  = 0;
    int          holds_served = 0;
    int          hold_left    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Dominant non-reference base of one sample, later base wins ties
    function automatic void dominant_base(input logic [16:0] sums [4], input logic [2:0] rbase,
                                          output logic [2:0] base, output logic [16:0] cnt);
        base = BASE_NONE;
        cnt  = '0;
        if (rbase <= BASE_G) begin
            for (int i = 0; i < 4; i++) begin
                if (i != rbase && sums[i] != 0 && sums[i] >= cnt) begin
                    cnt  = sums[i];
                    base = 3'(i);
                end
            end
        end
    endfunction

    // Classify one site and advance the running totals
    function automatic t_site_verdict classify_site(t_site s);
        logic [16:0]       asum [4];
        logic [16:0]       esum [4];
        logic [2:0]        allele, anc_base;
        logic [16:0]       m, am;
        longint unsigned   acov, ecov, mm, md, diff, rhs;
        logic [127:0]      lhs;
        longint            f, t, sd;
        t_outcome          oc;
        t_site_verdict     v;
        acov = 0;
        ecov = 0;
        for (int i = 0; i < 4; i++) begin
            asum[i] = 17'(s.afwd[16*i +: 16]) + 17'(s.arev[16*i +: 16]);
            esum[i] = 17'(s.efwd[16*i +: 16]) + 17'(s.erev[16*i +: 16]);
            acov += asum[i];
            ecov += esum[i];
        end
        dominant_base(esum, s.eref, allele, m);
        dominant_base(asum, s.aref, anc_base, am);
        mm = m;

        if (s.aref > BASE_G || s.eref > BASE_G) begin
            oc = OC_BAD_BASE;
        end else if (s.aref != s.eref) begin
            oc = OC_MISMATCH;
        end else if (acov < min_anc_cov) begin
            oc = OC_LOW_COV;
        end else if (am != 0) begin
            oc = OC_ANC_VAR;
        end else if (mm * max_freq_inv > ecov) begin
            oc = OC_FREQ_HIGH;
        end else begin
            oc = OC_UNMUTED;
            if (allele != BASE_NONE) begin
                f  = s.efwd[16*allele +: 16];
                t  = m;
                sd = 2 * f - t;
                if (sd * sd > 4 * t)
                    oc = OC_STRAND;
            end
            // exact form of f >= 1/D + alpha/sqrt(cov/3)
            if (oc != OC_STRAND && ecov != 0 && min_freq_div != 0) begin
                md = mm * min_freq_div;
                if (md >= ecov) begin
                    diff = md - ecov;
                    lhs  = 128'(diff) * 128'(diff) * 128'(10000);
                    rhs  = 3 * longint'(margin) * margin * ecov * min_freq_div * min_freq_div;
                    if (lhs >= 128'(rhs))
                        oc = OC_MUTED;
                end
            end
        end

        case (oc)
            OC_MUTED:   muted_cnt++;
            OC_UNMUTED: unmuted_cnt++;
            default:    discarded_cnt++;
        endcase
        v.outcome   = oc;
        v.allele    = allele;
        v.muted     = muted_cnt;
        v.unmuted   = unmuted_cnt;
        v.discarded = discarded_cnt;
        return v;
    endfunction

    function automatic logic [63:0] lanes4(int unsigned c0, int unsigned c1,
                                           int unsigned c2, int unsigned c3);
        return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
    endfunction

    function automatic t_site site_of(logic [2:0] aref, logic [2:0] eref,
                                      logic [63:0] afwd, logic [63:0] arev,
                                      logic [63:0] efwd, logic [63:0] erev);
        t_site s;
        s.aref = aref;
        s.afwd = afwd;
        s.arev = arev;
        s.eref = eref;
        s.efwd = efwd;
        s.erev = erev;
        return s;
    endfunction

    // Split n reads over the strands; strand-aware splits land near the imbalance limit
    function automatic void split_reads(int unsigned n, bit strand_aware,
                                        output int unsigned fw, output int unsigned rv);
        int unsigned lo, hi, root, dev;
        longint      c;
        lo = (n > 65535) ? n - 65535 : 0;
        hi = (n < 65535) ? n : 65535;
        if (strand_aware) begin
            root = 0;
            while ((root + 1) * (root + 1) <= n)
                root++;
            dev = $urandom_range(0, root * 3 / 2 + 1);
            c = longint'(n / 2) + ($urandom_range(0, 1) ? longint'(dev) : -longint'(dev));
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            fw = int'(c);
        end else begin
            fw = $urandom_range(lo, hi);
        end
        rv = n - fw;
    endfunction

    // Random site: mostly a clean ancestor and a plausible endpoint, some pure noise
    function automatic t_site gen_site();
        t_site       s;
        int unsigned r, alt, alt2, n, ecov_t, m, m2, refn, fw, rv, frac_top;
        s = '0;
        if ($urandom_range(0, 99) < 15) begin
            s.aref = 3'($urandom_range(0, 4));
            s.eref = ($urandom_range(0, 1)) ? s.aref : 3'($urandom_range(0, 4));
            s.afwd = {$urandom, $urandom};
            s.arev = {$urandom, $urandom};
            s.efwd = {$urandom, $urandom};
            s.erev = {$urandom, $urandom};
            return s;
        end
        r = $urandom_range(0, 3);
        s.aref = 3'(r);
        s.eref = 3'(r);

        // ancestor coverage around the threshold, mostly above it
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, MAX_SUM);
        else
            n = min_anc_cov + $urandom_range(0, 3000);
        if (n > MAX_SUM) n = MAX_SUM;
        split_reads(n, 1'b0, fw, rv);
        s.afwd[16*r +: 16] = 16'(fw);
        s.arev[16*r +: 16] = 16'(rv);
        if ($urandom_range(0, 11) == 0) begin
            alt = (r + $urandom_range(1, 3)) % 4;
            if ($urandom_range(0, 1))
                s.afwd[16*alt +: 16] = 16'($urandom_range(1, 3));
            else
                s.arev[16*alt +: 16] = 16'($urandom_range(1, 3));
        end
        if ($urandom_range(0, 24) == 0)
            s.eref = 3'((r + $urandom_range(1, 3)) % 4);

        // endpoint coverage and non-reference fraction near the cutoffs
        case ($urandom_range(0, 9))
            0:       ecov_t = $urandom_range(0, 40);
            1, 2, 3: ecov_t = $urandom_range(4000, MAX_SUM);
            default: ecov_t = $urandom_range(40, 4000);
        endcase
        frac_top = (max_freq_inv == 0) ? 400 : 1000 / max_freq_inv + 60;
        if (frac_top > 1000) frac_top = 1000;
        m = ($urandom_range(0, 19) == 0) ? 0 : ecov_t * $urandom_range(0, frac_top) / 1000;
        if (m > MAX_SUM) m = MAX_SUM;
        alt = (r + $urandom_range(1, 3)) % 4;
        split_reads(m, 1'b1, fw, rv);
        s.efwd[16*alt +: 16] = 16'(fw);
        s.erev[16*alt +: 16] = 16'(rv);

        // second allele, often tied with the first
        m2 = 0;
        if ($urandom_range(0, 3) == 0) begin
            do alt2 = $urandom_range(0, 3); while (alt2 == r || alt2 == alt);
            m2 = $urandom_range(0, 1) ? m : $urandom_range(0, m);
            split_reads(m2, 1'b1, fw, rv);
            s.efwd[16*alt2 +: 16] = 16'(fw);
            s.erev[16*alt2 +: 16] = 16'(rv);
        end
        refn = (ecov_t > m + m2) ? ecov_t - m - m2 : 0;
        if (refn > MAX_SUM) refn = MAX_SUM;
        split_reads(refn, 1'b0, fw, rv);
        s.efwd[16*r +: 16] = 16'(fw);
        s.erev[16*r +: 16] = 16'(rv);
        return s;
    endfunction

    // Config write; shadow copy is updated when the write is driven, ahead of the DUT register
    task automatic cfg_write(t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        case (idx)
            CFG_MIN_ANC_COV:  min_anc_cov  = MAC_W'(val);
            CFG_MAX_FREQ_INV: max_freq_inv = MFI_W'(val);
            CFG_MIN_FREQ_DIV: min_freq_div = DIV_W'(val);
            CFG_MARGIN:       margin       = MAR_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned mac, int unsigned mfi,
                                  int unsigned div, int unsigned mar);
        cfg_write(CFG_MIN_ANC_COV, mac);
        cfg_write(CFG_MAX_FREQ_INV, mfi);
        cfg_write(CFG_MIN_FREQ_DIV, div);
        cfg_write(CFG_MARGIN, mar);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_sites.size() != 0 || site_ch.valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic feed_random(int n, int gaps, int rmode, logic [7:0] pattern);
        gap_max     = gaps;
        rdy_mode    = rmode;
        rdy_pattern = pattern;
        repeat (n) pending_sites.push_back(gen_site());
    endtask

    // Sender: bursts of beats with random gaps; prediction at each accepted beat
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            site_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offer = site_ch.valid;
            if (site_ch.valid && site_ch.ready) begin
                expected_verdicts.push_back(classify_site(offered_site));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_sites.size() != 0) begin
                    offered_site = pending_sites.pop_front();
                    site_ch.ancestor_base           <= offered_site.aref;
                    site_ch.ancestor_forward_counts <= offered_site.afwd;
                    site_ch.ancestor_reverse_counts <= offered_site.arev;
                    site_ch.endpoint_base           <= offered_site.eref;
                    site_ch.endpoint_forward_counts <= offered_site.efwd;
                    site_ch.endpoint_reverse_counts <= offered_site.erev;
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
            end
            site_ch.valid <= offer;
        end
    end

    // Receiver: stall pattern per phase, plus long hold-offs on request
    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_left == 0 && holds_served != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            rdy_pattern = {rdy_pattern[0], rdy_pattern[7:1]};
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rdy_mode)
                    1:       rdy = ($urandom_range(0, 99) >= 30);
                    2:       rdy = rdy_pattern[0];
                    default: rdy = 1'b1;
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_site_verdict want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result beat with no site pending: outcome %0d", res_ch.outcome);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (res_ch.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, res_ch.outcome);
                    fail_count++;
                end
                if (res_ch.muted_allele !== want.allele) begin
                    $error("muted_allele: expected %0d, got %0d", want.allele,
                           res_ch.muted_allele);
                    fail_count++;
                end
                if (res_ch.muted_total !== want.muted) begin
                    $error("muted_total: expected %0d, got %0d", want.muted,
                           res_ch.muted_total);
                    fail_count++;
                end
                if (res_ch.unmuted_total !== want.unmuted) begin
                    $error("unmuted_total: expected %0d, got %0d", want.unmuted,
                           res_ch.unmuted_total);
                    fail_count++;
                end
                if (res_ch.discarded_total !== want.discarded) begin
                    $error("discarded_total: expected %0d, got %0d", want.discarded,
                           res_ch.discarded_total);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MIN_ANC_COV;
        i_cfg_data  = '0;
        site_ch.valid                   = 1'b0;
        site_ch.ancestor_base           = '0;
        site_ch.ancestor_forward_counts = '0;
        site_ch.ancestor_reverse_counts = '0;
        site_ch.endpoint_base           = '0;
        site_ch.endpoint_forward_counts = '0;
        site_ch.endpoint_reverse_counts = '0;
        res_ch.ready                    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sites under reset config (100, 5, 8, 52)
        gap_max  = 0;
        rdy_mode = 0;
        pending_sites.push_back(site_of(BASE_A, BASE_A, '0, '0, '0, '0));      // low coverage
        pending_sites.push_back(site_of(BASE_A, BASE_A, '1, '1, '1, '1));      // ancestor variant
        pending_sites.push_back(site_of(BASE_NONE, BASE_NONE, '1, '1, '1, '1));
        pending_sites.push_back(site_of(BASE_A, BASE_NONE, lanes4(300, 0, 0, 0), '0,
                                        lanes4(900, 300, 0, 0), '0));           // bad endpoint base
        pending_sites.push_back(site_of(BASE_NONE, 3'd1, '0, '0, '0, '0));
        pending_sites.push_back(site_of(3'd1, 3'd2, lanes4(0, 300, 0, 0), '0,
                                        lanes4(0, 0, 500, 0), '0));             // reference mismatch
        // muted, not muted, strand, freq high
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), lanes4(100, 0, 0, 0),
                                        lanes4(1000, 250, 0, 0), lanes4(1000, 250, 0, 0)));
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), lanes4(100, 0, 0, 0),
                                        lanes4(1100, 150, 0, 0), lanes4(1100, 150, 0, 0)));
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), lanes4(100, 0, 0, 0),
                                        lanes4(1000, 500, 0, 0), lanes4(1000, 0, 0, 0)));
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), lanes4(100, 0, 0, 0),
                                        lanes4(950, 300, 0, 0), lanes4(950, 300, 0, 0)));
        // empty endpoint; endpoint with reference reads only
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), '0, '0, '0));
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), '0,
                                        lanes4(1000, 0, 0, 0), lanes4(500, 0, 0, 0)));
        // tie between T and G goes to G
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(200, 0, 0, 0), '0,
                                        lanes4(800, 150, 0, 150), lanes4(800, 150, 0, 150)));
        // full lanes
        pending_sites.push_back(site_of(BASE_G, BASE_G, lanes4(0, 0, 0, 65535),
                                        lanes4(0, 0, 0, 65535), lanes4(65535, 0, 0, 65535),
                                        lanes4(65535, 0, 0, 65535)));
        // single stray ancestor read
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(300, 0, 0, 0), lanes4(0, 0, 1, 0),
                                        lanes4(1000, 250, 0, 0), lanes4(1000, 250, 0, 0)));
        // coverage threshold edges
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(99, 0, 0, 0), '0,
                                        lanes4(1000, 250, 0, 0), lanes4(1000, 250, 0, 0)));
        pending_sites.push_back(site_of(BASE_A, BASE_A, lanes4(60, 0, 0, 0), lanes4(40, 0, 0, 0),
                                        lanes4(1000, 250, 0, 0), lanes4(1000, 250, 0, 0)));
        // muted site on every reference base
        for (int r = 0; r < 4; r++) begin
            logic [63:0] anc, ep;
            anc = '0;
            ep  = '0;
            anc[16*r +: 16] = 16'd300;
            ep[16*r +: 16]  = 16'd1000;
            ep[16*((r + 1) % 4) +: 16] = 16'd250;
            pending_sites.push_back(site_of(3'(r), 3'(r), anc, '0, ep, ep));
        end
        feed_random(60, 0, 0, 8'hFF);
        wait_drained();

        // Extremes: no coverage floor, tightest freq limit, largest divisor, no margin
        apply_settings(0, 255, 1023, 0);
        feed_random(50, 4, 1, 8'hFF);
        wait_drained();

        // Extremes: highest coverage floor, loosest freq limit, smallest divisor, full margin
        apply_settings(524280, 1, 1, 100);
        feed_random(30, 2, 2, 8'b1011_0110);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        apply_settings(100, 5, 8, 52);
        holds_asked++;
        feed_random(100, 0, 1, 8'hFF);
        wait_drained();

        // Zero divisor and zero freq limit
        apply_settings(60, 0, 0, 52);
        feed_random(40, 3, 2, 8'b1100_1010);
        wait_drained();

        // Random settings
        for (int p = 0; p < 4; p++) begin
            if (p == 3)
                apply_settings($urandom_range(0, 524280), $urandom_range(1, 255),
                               $urandom_range(1, 1023), $urandom_range(0, 100));
            else
                apply_settings($urandom_range(0, 2000), $urandom_range(1, 12),
                               $urandom_range(2, 40), $urandom_range(0, 100));
            feed_random(40, $urandom_range(0, 8), $urandom_range(0, 2), 8'($urandom));
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pscm_pkg.sv
rtl/pscm_site_if.sv
rtl/pscm_result_if.sv
rtl/pscm_pipe.sv
rtl/pileup_site_mutation_classifier_unit.sv
test/pileup_site_mutation_classifier_unit_tb.sv
